[rtl/sqa_pkg.sv]
// Shared types and constants for the saturating Q-format ALU.
// No dependencies.
`default_nettype none
package sqa_pkg;
    localparam int unsigned DivW = 48;   // dividend magnitude width
    localparam int unsigned DenW = 32;   // divisor magnitude width

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_QMUL = 3'd1,
        OP_IMUL = 3'd2,
        OP_QDIV = 3'd3,
        OP_IDIV = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    // Control carried alongside the divider cells
    typedef struct packed {
        logic       valid;
        logic [2:0] op;
        logic       neg;      // quotient sign
        logic       div0;
        logic       a_neg;
        logic signed [33:0] direct; // non-divide value, already final
    } ctl_t;

    // One cell: restoring divide step on magnitudes
    typedef struct packed {
        logic [DivW-1:0] rem;
        logic [DivW-1:0] quo;
        logic [DenW-1:0] den;
    } div_t;
endpackage
`default_nettype wire

[rtl/sqa_cell.sv]
// One stage of the divider chain: one quotient bit per cycle while advance is high.
// Depends on sqa_pkg.
`default_nettype none
module sqa_cell
    import sqa_pkg::*;
#(
    parameter int unsigned BIT = 0
) (
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic advance,
    input  wire  ctl_t ctl_in,
    input  wire  div_t dat_in,
    output ctl_t ctl_reg,
    output div_t dat_reg
);
    logic [DivW+DenW:0] part;
    logic [DivW+DenW:0] trial;
    div_t dat_next;

    always_comb
    begin
        // remainder holds the not-yet-consumed high dividend bits
        part  = {{(DenW+1){1'b0}}, dat_in.rem} >> BIT;
        trial = part - {{(DivW+1){1'b0}}, dat_in.den};
        dat_next = dat_in;
        if (!trial[DivW+DenW])
        begin
            dat_next.rem = dat_in.rem - (DivW'(dat_in.den) << BIT);
            dat_next.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (advance)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            dat_reg <= dat_next;
    end
endmodule
`default_nettype wire

[rtl/saturating_q_format_alu.sv]
// Saturating 16-bit Q-format ALU, top level.
// All ops share the pipe: stage A, stage B, the 48-cell divider chain and the output register.
// Throughput: one transaction per cycle while the output is not stalled; one quotient bit
// per divider cell. Reset clears all valid flags and sets frac_bits to 15.
// Depends on sqa_pkg and sqa_cell.
`default_nettype none
module saturating_q_format_alu
    import sqa_pkg::*;
(
    input  wire  logic               clk,
    input  wire  logic               rst_n,
    input  wire  logic               cfg_valid,
    output logic                     cfg_ready,
    input  wire  logic [3:0]         cfg_data,
    input  wire  logic               in_valid,
    output logic                     in_ready,
    input  wire  logic [2:0]         op,
    input  wire  logic signed [31:0] operand_a,
    input  wire  logic signed [31:0] operand_b,
    output logic                     out_valid,
    input  wire  logic               out_ready,
    output logic signed [15:0]       result,
    output logic [1:0]               status
);
    logic [3:0] frac_bits_reg;
    logic       advance;
    ctl_t       ctl0_reg;
    ctl_t       ctl0_next;
    div_t       dat0_reg;
    div_t       dat0_next;
    logic signed [31:0] prod_reg;
    ctl_t       pre_reg;
    logic [3:0] pre_q_reg;
    logic signed [47:0] t_reg;
    logic signed [31:0] b_reg;

    ctl_t ctl_c [DivW+1];
    div_t dat_c [DivW+1];

    assign cfg_ready = 1'b1;
    // output register is the chain end; stall whole chain when it is full
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frac_bits_reg <= 4'd15;
        else if (cfg_valid && cfg_ready)
            frac_bits_reg <= cfg_data;
    end

    // stage A: multiply, operand setup
    logic signed [15:0] a16;
    logic signed [15:0] b16;
    logic signed [47:0] t_next;
    logic signed [31:0] b_next;
    logic signed [33:0] add_v;
    always_comb
    begin
        a16 = operand_a[15:0];
        b16 = operand_b[15:0];
        add_v = 34'(a16) + 34'(b16);
        if (op == OP_IDIV)
        begin
            t_next = 48'(operand_a);
            b_next = operand_b;
        end
        else
        begin
            t_next = 48'(a16) <<< frac_bits_reg;
            b_next = 32'(b16);
            if (op != OP_QDIV)
                t_next = 48'(a16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_reg <= '0;
        else if (advance)
        begin
            pre_reg.valid  <= in_valid;
            pre_reg.op     <= op;
            pre_reg.neg    <= 1'b0;
            pre_reg.div0   <= (b_next == 32'sd0);
            pre_reg.a_neg  <= t_next[47];
            pre_reg.direct <= add_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pre_q_reg      <= frac_bits_reg;
            prod_reg       <= a16 * b16;
            t_reg          <= t_next;
            b_reg          <= b_next;
        end
    end

    // stage B: finish multiply ops, rounding and magnitudes for divide
    logic signed [48:0] tr;
    logic signed [48:0] bh;
    logic signed [33:0] qm;
    logic [48:0] tmag;
    always_comb
    begin
        ctl0_next = pre_reg;
        qm = 34'(prod_reg);
        if (pre_q_reg != 4'd0)
            qm = qm + (34'sd1 <<< (pre_q_reg - 4'd1));
        qm = qm >>> pre_q_reg;
        if (pre_reg.op == OP_QMUL)
            ctl0_next.direct = qm;
        else if (pre_reg.op == OP_IMUL)
            ctl0_next.direct = 34'(prod_reg);
        bh = 49'(b_reg / 2);
        if (t_reg[47] == b_reg[31])
            tr = 49'(t_reg) + bh;
        else
            tr = 49'(t_reg) - bh;
        ctl0_next.neg = tr[48] ^ b_reg[31];
        tmag = tr[48] ? -tr : tr;
        dat0_next.rem = tmag[DivW-1:0];
        dat0_next.quo = '0;
        dat0_next.den = b_reg[31] ? DenW'(-b_reg) : DenW'(b_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl0_reg <= '0;
        else if (advance)
            ctl0_reg <= ctl0_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            dat0_reg <= dat0_next;
    end

    assign ctl_c[0] = ctl0_reg;
    assign dat_c[0] = dat0_reg;

    for (genvar i = 0; i < DivW; i++)
    begin : g_cell
        sqa_cell #(.BIT(DivW - 1 - i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .ctl_in  (ctl_c[i]),
            .dat_in  (dat_c[i]),
            .ctl_reg (ctl_c[i+1]),
            .dat_reg (dat_c[i+1])
        );
    end

    // output: sign, clamp, status
    ctl_t cf;
    logic signed [49:0] v;
    logic signed [15:0] res_next;
    logic [1:0] st_next;
    always_comb
    begin
        cf = ctl_c[DivW];
        if (cf.op == OP_QDIV || cf.op == OP_IDIV)
            v = cf.neg ? -50'($unsigned(dat_c[DivW].quo)) : 50'($unsigned(dat_c[DivW].quo));
        else
            v = 50'(cf.direct);
        st_next = ST_OK;
        if (v > 50'sd32767)
        begin
            res_next = 16'sh7fff;
            st_next = ST_SAT;
        end
        else if (v < -50'sd32768)
        begin
            res_next = -16'sh8000;
            st_next = ST_SAT;
        end
        else
            res_next = v[15:0];
        if ((cf.op == OP_QDIV || cf.op == OP_IDIV) && cf.div0)
        begin
            res_next = cf.a_neg ? -16'sh8000 : 16'sh7fff;
            st_next = ST_DIV0;
        end
        if (cf.op > OP_IDIV)
        begin
            res_next = '0;
            st_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (advance)
            out_valid <= cf.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result <= res_next;
            status <= st_next;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("result changed while stalled");
    a_no_ready_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output blocked");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status");
endmodule
`default_nettype wire

[tb/saturating_q_format_alu_test.sv]
// Testbench for saturating_q_format_alu: directed corners, then random operations
// under several frac_bits settings and handshake idling patterns. Depends on sqa_pkg
// and the RTL only; results are checked against an in-bench predictor.
`timescale 1ns / 1ps
`default_nettype none

module saturating_q_format_alu_test;
    import sqa_pkg::*;

    localparam int  LatencyCycles = 60;
    localparam int  CycleLimit    = 300000;
    localparam longint SatMax     = 32767;
    localparam longint SatMin     = -32768;
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    typedef struct {
        logic signed [15:0] value;
        logic [1:0]         st;
    } alu_result_t;

    class alu_scoreboard;
        alu_result_t expected_q[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function longint round_div(longint t, longint d);
            if ((t >= 0) == (d >= 0))
                t += d / 2;
            else
                t -= d / 2;
            return t / d;
        endfunction

        function alu_result_t predict(logic [2:0] code, logic [31:0] a, logic [31:0] b,
                                      logic [3:0] q);
            alu_result_t r;
            longint a16;
            longint b16;
            longint a32;
            longint b32;
            longint v;
            bit     div0;
            a16 = longint'($signed(a[15:0]));
            b16 = longint'($signed(b[15:0]));
            a32 = longint'($signed(a));
            b32 = longint'($signed(b));
            div0 = 0;
            v = 0;
            case (code)
                OP_ADD: v = a16 + b16;
                OP_QMUL:
                begin
                    v = a16 * b16;
                    if (q > 0)
                        v += longint'(1) << (q - 1);
                    v = v >>> q;
                end
                OP_IMUL: v = a16 * b16;
                OP_QDIV:
                begin
                    if (b16 == 0)
                    begin
                        div0 = 1;
                        v = (a16 >= 0) ? SatMax : SatMin;
                    end
                    else
                        v = round_div(a16 <<< q, b16);
                end
                OP_IDIV:
                begin
                    if (b32 == 0)
                    begin
                        div0 = 1;
                        v = (a32 >= 0) ? SatMax : SatMin;
                    end
                    else
                        v = round_div(a32, b32);
                end
                default:
                begin
                    r.value = '0;
                    r.st = ST_OK;
                    return r;
                end
            endcase
            r.st = ST_OK;
            if (v > SatMax)
            begin
                v = SatMax;
                r.st = ST_SAT;
            end
            else if (v < SatMin)
            begin
                v = SatMin;
                r.st = ST_SAT;
            end
            if (div0)
                r.st = ST_DIV0;
            r.value = v[15:0];
            return r;
        endfunction

        function void note(logic [2:0] code, logic [31:0] a, logic [31:0] b, logic [3:0] q);
            expected_q.push_back(predict(code, a, b, q));
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check(logic signed [15:0] value, logic [1:0] st);
            alu_result_t e;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result %0d status %0d", value, st));
                return;
            end
            e = expected_q.pop_front();
            if (value !== e.value)
                report($sformatf("result %0d, expected %0d", value, e.value));
            if (st !== e.st)
                report($sformatf("status %0d, expected %0d", st, e.st));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [3:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] result;
    logic [1:0]         status;

    alu_scoreboard sb;
    logic [3:0]    frac_bits;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_cycles;
    int            cycle_count;

    saturating_q_format_alu DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result(result),
        .status(status)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Receiver: check at the rising edge, pick out_ready at the falling edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check(result, status);
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send(logic [2:0] code, logic [31:0] a, logic [31:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid  = 1;
        op        = code;
        operand_a = a;
        operand_b = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note(code, a, b, frac_bits);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LatencyCycles) @(posedge clk);
    endtask

    task automatic write_frac(logic [3:0] value);
        drain();
        @(negedge clk);
        cfg_valid = 1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        frac_bits = value;
        @(negedge clk);
        cfg_valid = 0;
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(400)) - 200);
            2:
            begin
                case ($urandom_range(5))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_7fff;
                    3: return 32'hffff_8000;
                    4: return 32'hffff_ffff;
                    default: return 32'h0;
                endcase
            end
            3: return {16'($urandom_range(65535)), 16'($urandom)};
            default: return 32'($signed(16'($urandom)));
        endcase
    endfunction

    task automatic send_random(int count);
        logic [2:0]  code;
        logic [31:0] a;
        logic [31:0] b;
        repeat (count)
        begin
            if ($urandom_range(19) == 0)
                code = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
            else
                code = 3'($urandom_range(OP_ADD, OP_IDIV));
            a = rand_operand();
            b = rand_operand();
            // keep some integer divides in range
            if (code == OP_IDIV && $urandom_range(1))
                a = 32'($signed($urandom_range(2000000)) - 1000000);
            send(code, a, b);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = '0;
        in_valid = 0;
        op = OP_ADD;
        operand_a = '0;
        operand_b = '0;
        out_ready = 0;
        hold_cycles = 0;
        cycle_count = 0;
        frac_bits = 4'd15;
        send_idle_pct = 11;
        recv_idle_pct = 76;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed corners at the reset format
        send(OP_ADD,  32'h0000_7fff, 32'h0000_7fff);
        send(OP_ADD,  32'h0000_8000, 32'h0000_8000);
        send(OP_ADD,  32'hffff_0005, 32'h1234_fffb);
        send(OP_QMUL, 32'h0000_8000, 32'h0000_8000);
        send(OP_QMUL, 32'h0000_4000, 32'hffff_c000);
        send(OP_QMUL, 32'h0000_0001, 32'h0000_4000);
        send(OP_IMUL, 32'h0000_0100, 32'h0000_0100);
        send(OP_IMUL, 32'h0000_8000, 32'h0000_7fff);
        send(OP_IMUL, 32'h0000_0007, 32'hffff_fffa);
        send(OP_QDIV, 32'h0000_1234, 32'h0000_0000);
        send(OP_QDIV, 32'h0000_8000, 32'hffff_0000);
        send(OP_QDIV, 32'h0000_2000, 32'h0000_4000);
        send(OP_QDIV, 32'hffff_e000, 32'h0000_3000);
        send(OP_IDIV, 32'h8000_0000, 32'hffff_ffff);
        send(OP_IDIV, 32'h7fff_ffff, 32'h0000_0000);
        send(OP_IDIV, 32'h8000_0000, 32'h0000_0000);
        send(OP_IDIV, 32'h0000_0007, 32'h0000_0002);
        send(OP_IDIV, 32'hffff_fff9, 32'h0000_0002);
        send(OP_IDIV, 32'h7fff_ffff, 32'h7fff_ffff);
        send(OP_SPARE5, 32'h7fff_ffff, 32'h8000_0000);
        send(OP_SPARE7, 32'hffff_ffff, 32'hffff_ffff);
        send_random(80);

        write_frac(4'd0);
        send(OP_QMUL, 32'h0000_0003, 32'hffff_fffb);
        send(OP_QDIV, 32'h0000_0007, 32'h0000_0002);
        send_random(80);

        write_frac(4'd1);
        send_random(80);

        send_idle_pct = 76;
        recv_idle_pct = 11;
        write_frac(4'd8);
        send_random(90);

        write_frac(4'd15);
        send_random(90);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_frac(4'd4);
        // stall the output long enough for the pipe to back up into the input
        hold_cycles = 400;
        send_random(120);
        drain();

        write_frac(4'd12);
        send_random(140);
        drain();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

`default_nettype wire
